FILE: hw/rtl/wav_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wav_pkg: shared constants for the wav pcm stream parser
// Header layout, tag bytes, result kinds and error codes.
// ----------------------------------------------------------------------------
package wav_pkg;

	// field widths
	localparam int unsigned ByteW   = 8;
	localparam int unsigned KindW   = 2;
	localparam int unsigned SampleW = 32;
	localparam int unsigned RateW   = 32;
	localparam int unsigned ErrW    = 4;
	localparam int unsigned OutDataW = 72;   // sample, rate, error, zero fill

	// header geometry
	localparam int unsigned HdrCntW = 6;
	localparam logic [HdrCntW-1:0] HEADER_LAST = 6'd43;

	// result kinds
	localparam logic [KindW-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KindW-1:0] KIND_HEADER = 2'd1;
	localparam logic [KindW-1:0] KIND_ERROR  = 2'd2;

	// error codes
	localparam logic [ErrW-1:0] ERR_SHORT_HDR  = 4'd0;
	localparam logic [ErrW-1:0] ERR_RIFF       = 4'd1;
	localparam logic [ErrW-1:0] ERR_WAVE       = 4'd2;
	localparam logic [ErrW-1:0] ERR_FMT        = 4'd3;
	localparam logic [ErrW-1:0] ERR_NOT_PCM    = 4'd4;
	localparam logic [ErrW-1:0] ERR_NOT_MONO   = 4'd5;
	localparam logic [ErrW-1:0] ERR_DATA_TAG   = 4'd6;
	localparam logic [ErrW-1:0] ERR_BLK_ALIGN  = 4'd7;
	localparam logic [ErrW-1:0] ERR_SHORT_DATA = 4'd8;

	// tag mismatch flag positions
	localparam int unsigned FLAG_RIFF = 0;
	localparam int unsigned FLAG_WAVE = 1;
	localparam int unsigned FLAG_FMT  = 2;
	localparam int unsigned FLAG_DATA = 3;

	// expected tag byte by tag and byte position
	function automatic logic [ByteW-1:0] tag_byte(input int unsigned flag,
			input logic [1:0] idx);
		logic [31:0] word;
		begin
			case (flag)
				FLAG_RIFF: word = 32'h52494646;   // "RIFF"
				FLAG_WAVE: word = 32'h57415645;   // "WAVE"
				FLAG_FMT:  word = 32'h666D7420;   // "fmt "
				default:   word = 32'h64617461;   // "data"
			endcase
			case (idx)
				2'd0:    tag_byte = word[31:24];
				2'd1:    tag_byte = word[23:16];
				2'd2:    tag_byte = word[15:8];
				default: tag_byte = word[7:0];
			endcase
		end
	endfunction

endpackage : wav_pkg
`default_nettype wire

FILE: hw/rtl/wav_pcm_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser: byte-serial mono pcm wav parser
// Checks the 44-byte canonical header and turns data blocks into q1.31.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one file byte per item in s_tdata. s_tlast marks an
//   end-of-file item that carries no byte; s_tuser set clears the parser
//   before the item is taken (start of a new file).
//   m_* carries at most one result per input item: m_tuser is the kind
//   (sample, header accepted, error), m_tdata holds sample, rate and error.
//   The header result appears after the 44th byte, one sample after each
//   completed block of block-align bytes, an error on a failed header check
//   or on end of file before the parser has stopped.
// Throughput and timing:
//   one byte per cycle while s_tready is high; a result is valid on m_* in
//   the cycle after the item that caused it, as the single output register
//   holds it. A new item is taken whenever it is empty or being drained.
// Reset and stall:
//   arst_n clears the parser to the header phase and empties the output.
//   While m_tready is low with a result pending, s_tready drops and the
//   pending result holds.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// bits: data_byte[7:0]
	input  wire logic [wav_pkg::ByteW-1:0]       s_tdata,
	input  wire logic                            s_tlast,
	// bits: new_file[0]
	input  wire logic                            s_tuser,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// bits: sample_value[31:0], sample_rate[63:32], error_code[67:64], zero[71:68]
	output      logic [wav_pkg::OutDataW-1:0]    m_tdata,
	// bits: result_kind[1:0]
	output      logic [wav_pkg::KindW-1:0]       m_tuser,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready
);
	import wav_pkg::*;

	typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_STOP} phase_t;

	// parser state
	phase_t               phase_q;
	logic [HdrCntW-1:0]   hdr_cnt_q;
	logic [3:0]           tag_flags_q;
	logic [15:0]          audio_fmt_q;
	logic [15:0]          chan_cnt_q;
	logic [RateW-1:0]     rate_q;
	logic [15:0]          blk_align_q;
	logic [15:0]          bits_q;
	logic [31:0]          left_q;
	logic [1:0]           blk_idx_q;
	logic [31:0]          asm_q;

	// output register
	logic                 out_valid_q;
	logic [KindW-1:0]     out_kind_q;
	logic [SampleW-1:0]   out_smp_q;
	logic [RateW-1:0]     out_rate_q;
	logic [ErrW-1:0]      out_err_q;

	// state seen by this item, after an optional clear
	phase_t               cur_phase;
	logic [HdrCntW-1:0]   cur_cnt;
	logic [3:0]           cur_flags;
	logic [15:0]          cur_fmt, cur_chan, cur_align, cur_bits;
	logic [RateW-1:0]     cur_rate;
	logic [31:0]          cur_left, cur_asm;
	logic [1:0]           cur_idx;

	// next state and result
	phase_t               nxt_phase;
	logic [HdrCntW-1:0]   nxt_cnt;
	logic [3:0]           nxt_flags;
	logic [15:0]          nxt_fmt, nxt_chan, nxt_align, nxt_bits;
	logic [RateW-1:0]     nxt_rate;
	logic [31:0]          nxt_left, nxt_asm, left_sub;
	logic [1:0]           nxt_idx;
	logic                 res_valid;
	logic [KindW-1:0]     res_kind;
	logic [SampleW-1:0]   res_smp;
	logic [ErrW-1:0]      res_err;
	logic [ErrW-1:0]      hdr_err;
	logic                 hdr_bad;
	logic [ByteW-1:0]     b;
	logic [HdrCntW-1:0]   pos;
	logic                 in_fire;

	assign in_fire  = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign b        = s_tdata;

	// clear on new file
	always_comb begin
		if (s_tuser) begin
			cur_phase = PH_HEADER;
			cur_cnt   = '0;
			cur_flags = '0;
			cur_fmt   = '0;
			cur_chan  = '0;
			cur_rate  = '0;
			cur_align = '0;
			cur_bits  = '0;
			cur_left  = '0;
			cur_idx   = '0;
			cur_asm   = '0;
		end else begin
			cur_phase = phase_q;
			cur_cnt   = hdr_cnt_q;
			cur_flags = tag_flags_q;
			cur_fmt   = audio_fmt_q;
			cur_chan  = chan_cnt_q;
			cur_rate  = rate_q;
			cur_align = blk_align_q;
			cur_bits  = bits_q;
			cur_left  = left_q;
			cur_idx   = blk_idx_q;
			cur_asm   = asm_q;
		end
	end

	// header capture, checks and block assembly
	always_comb begin
		pos       = cur_cnt;
		nxt_phase = cur_phase;
		nxt_cnt   = cur_cnt;
		nxt_flags = cur_flags;
		nxt_fmt   = cur_fmt;
		nxt_chan  = cur_chan;
		nxt_rate  = cur_rate;
		nxt_align = cur_align;
		nxt_bits  = cur_bits;
		nxt_left  = cur_left;
		nxt_idx   = cur_idx;
		nxt_asm   = cur_asm;
		left_sub  = '0;
		hdr_err   = ERR_SHORT_HDR;
		hdr_bad   = 1'b0;
		res_valid = 1'b0;
		res_kind  = KIND_SAMPLE;
		res_smp   = '0;
		res_err   = ERR_SHORT_HDR;

		if (s_tlast) begin
			if (cur_phase == PH_HEADER) begin
				nxt_phase = PH_STOP;
				res_valid = 1'b1;
				res_kind  = KIND_ERROR;
				res_err   = ERR_SHORT_HDR;
			end else if (cur_phase == PH_DATA) begin
				nxt_phase = PH_STOP;
				res_valid = 1'b1;
				res_kind  = KIND_ERROR;
				res_err   = ERR_SHORT_DATA;
			end
		end else if (cur_phase == PH_HEADER) begin
			// capture this header byte
			if (pos < 6'd4) begin
				if (b != tag_byte(FLAG_RIFF, pos[1:0])) nxt_flags[FLAG_RIFF] = 1'b1;
			end else if (pos >= 6'd8 && pos < 6'd12) begin
				if (b != tag_byte(FLAG_WAVE, pos[1:0])) nxt_flags[FLAG_WAVE] = 1'b1;
			end else if (pos >= 6'd12 && pos < 6'd16) begin
				if (b != tag_byte(FLAG_FMT, pos[1:0])) nxt_flags[FLAG_FMT] = 1'b1;
			end else if (pos >= 6'd20 && pos < 6'd22) begin
				nxt_fmt = cur_fmt | (16'(b) << {pos[0], 3'b000});
			end else if (pos >= 6'd22 && pos < 6'd24) begin
				nxt_chan = cur_chan | (16'(b) << {pos[0], 3'b000});
			end else if (pos >= 6'd24 && pos < 6'd28) begin
				nxt_rate = cur_rate | (32'(b) << {pos[1:0], 3'b000});
			end else if (pos >= 6'd32 && pos < 6'd34) begin
				nxt_align = cur_align | (16'(b) << {pos[0], 3'b000});
			end else if (pos >= 6'd34 && pos < 6'd36) begin
				nxt_bits = cur_bits | (16'(b) << {pos[0], 3'b000});
			end else if (pos >= 6'd36 && pos < 6'd40) begin
				if (b != tag_byte(FLAG_DATA, pos[1:0])) nxt_flags[FLAG_DATA] = 1'b1;
			end else if (pos >= 6'd40 && pos < 6'd44) begin
				nxt_left = cur_left | (32'(b) << {pos[1:0], 3'b000});
			end
			nxt_cnt = cur_cnt + 6'd1;

			// first failing check wins
			if (nxt_flags[FLAG_RIFF]) begin
				hdr_bad = 1'b1; hdr_err = ERR_RIFF;
			end else if (nxt_flags[FLAG_WAVE]) begin
				hdr_bad = 1'b1; hdr_err = ERR_WAVE;
			end else if (nxt_flags[FLAG_FMT]) begin
				hdr_bad = 1'b1; hdr_err = ERR_FMT;
			end else if (nxt_fmt != 16'd1) begin
				hdr_bad = 1'b1; hdr_err = ERR_NOT_PCM;
			end else if (nxt_chan != 16'd1) begin
				hdr_bad = 1'b1; hdr_err = ERR_NOT_MONO;
			end else if (nxt_flags[FLAG_DATA]) begin
				hdr_bad = 1'b1; hdr_err = ERR_DATA_TAG;
			end else if (nxt_align < 16'd1 || nxt_align > 16'd4) begin
				hdr_bad = 1'b1; hdr_err = ERR_BLK_ALIGN;
			end

			// last header byte: report
			if (pos == HEADER_LAST) begin
				res_valid = 1'b1;
				if (hdr_bad) begin
					nxt_phase = PH_STOP;
					res_kind  = KIND_ERROR;
					res_err   = hdr_err;
				end else begin
					nxt_idx   = '0;
					nxt_asm   = '0;
					nxt_phase = (nxt_left < 32'(nxt_align)) ? PH_STOP : PH_DATA;
					res_kind  = KIND_HEADER;
				end
			end
		end else if (cur_phase == PH_DATA) begin
			// little-endian block assembly
			nxt_asm = cur_asm | (32'(b) << {cur_idx, 3'b000});
			if (({1'b0, cur_idx} + 3'd1) >= cur_align[2:0] || cur_align[15:3] != '0) begin
				case (cur_bits)
					16'd8:   res_smp = {nxt_asm[7:0], 24'd0};
					16'd16:  res_smp = {nxt_asm[15:0], 16'd0};
					16'd32:  res_smp = nxt_asm;
					default: res_smp = '0;
				endcase
				left_sub  = cur_left - 32'(cur_align);
				nxt_left  = left_sub;
				nxt_idx   = '0;
				nxt_asm   = '0;
				if (left_sub < 32'(cur_align)) nxt_phase = PH_STOP;
				res_valid = 1'b1;
				res_kind  = KIND_SAMPLE;
			end else begin
				nxt_idx = cur_idx + 2'd1;
			end
		end
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= '0;
			tag_flags_q <= '0;
			audio_fmt_q <= '0;
			chan_cnt_q  <= '0;
			rate_q      <= '0;
			blk_align_q <= '0;
			bits_q      <= '0;
			left_q      <= '0;
			blk_idx_q   <= '0;
			asm_q       <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_SAMPLE;
			out_smp_q   <= '0;
			out_rate_q  <= '0;
			out_err_q   <= ERR_SHORT_HDR;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				phase_q     <= nxt_phase;
				hdr_cnt_q   <= nxt_cnt;
				tag_flags_q <= nxt_flags;
				audio_fmt_q <= nxt_fmt;
				chan_cnt_q  <= nxt_chan;
				rate_q      <= nxt_rate;
				blk_align_q <= nxt_align;
				bits_q      <= nxt_bits;
				left_q      <= nxt_left;
				blk_idx_q   <= nxt_idx;
				asm_q       <= nxt_asm;
				if (res_valid) begin
					out_valid_q <= 1'b1;
					out_kind_q  <= res_kind;
					out_smp_q   <= (res_kind == KIND_SAMPLE) ? res_smp : '0;
					out_rate_q  <= (res_kind == KIND_HEADER) ? nxt_rate : '0;
					out_err_q   <= (res_kind == KIND_ERROR) ? res_err : ERR_SHORT_HDR;
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {4'd0, out_err_q, out_rate_q, out_smp_q};

endmodule : wav_pcm_stream_parser
`default_nettype wire
